// ----- rtl/hci_uart_h4_deframer_assert.svh -----
// Assertion macros used by the H4 deframer back part.
// No dependencies; included by hci_h4_back.
`ifndef HCI_UART_H4_DEFRAMER_ASSERT_SVH
`define HCI_UART_H4_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HCI_H4_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define HCI_H4_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/hci_h4_pkg.sv -----
// Shared types and constants of the HCI H4 UART receive deframer.
// No dependencies; compiled first.
package hci_h4_pkg;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int EVT_LIMIT_W = 9;
  localparam int ACL_LIMIT_W = 16;
  localparam int COUNT_OUT_W = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_EVENT_SIZE_LIMIT  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACL_PAYLOAD_LIMIT = 1'b1;

  localparam logic [EVT_LIMIT_W-1:0] EVT_LIMIT_RESET = 9'd70;
  localparam logic [ACL_LIMIT_W-1:0] ACL_LIMIT_RESET = 16'd1025;

  localparam logic [7:0] TYPE_EVENT           = 8'h04;
  localparam logic [7:0] TYPE_ACL             = 8'h02;
  localparam logic [7:0] EVT_LE_META          = 8'h3E;
  localparam logic [7:0] SUBEV_ADV_REPORT     = 8'h02;
  localparam logic [7:0] SUBEV_EXT_ADV_REPORT = 8'h0D;

  // code byte plus length byte
  localparam logic [9:0] EVT_HDR_BYTES = 10'd2;

  localparam int QUEUE_DEPTH_DEFAULT      = 4;
  localparam int DROP_COUNT_WIDTH_DEFAULT = 32;

  typedef enum logic [2:0] {
    OP_BYTE,
    OP_EVT_HDR,
    OP_ACL_HDR,
    OP_EVT_DROP,
    OP_ACL_DROP
  } op_t;

  typedef enum logic [1:0] {
    KIND_EVT_BYTE,
    KIND_ACL_BYTE,
    KIND_EVT_DROP,
    KIND_ACL_DROP
  } kind_t;

  // One queue entry: a body byte, a whole header or a drop notice.
  typedef struct packed {
    op_t             op;
    logic [3:0][7:0] data;
    logic            acl;
    logic            last;
    logic            disc;
  } cmd_t;

endpackage

// ----- rtl/hci_h4_channels.sv -----
// Valid/ready channels of the deframer: received bytes and packet words.
// No dependencies.
interface hci_h4_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface hci_h4_pkt_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [1:0]  out_kind;
  logic        first_of_packet;
  logic        last_of_packet;
  logic        discardable;
  logic [31:0] dropped_event_total;
  logic [31:0] dropped_acl_total;
  modport source (output valid, output out_byte, output out_kind,
                  output first_of_packet, output last_of_packet, output discardable,
                  output dropped_event_total, output dropped_acl_total, input ready);
  modport sink (input valid, input out_byte, input out_kind,
                input first_of_packet, input last_of_packet, input discardable,
                input dropped_event_total, input dropped_acl_total, output ready);
endinterface

// ----- rtl/hci_h4_front.sv -----
// Front part: accepts received bytes, tracks the H4 framing and pushes
// commands into the queue. Depends on hci_h4_pkg and hci_h4_rx_if.
module hci_h4_front import hci_h4_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  hci_h4_rx_if.sink              link,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   q_full,
  output logic                   q_push,
  output cmd_t                   q_cmd
);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_EVT_HDR,
    PH_EVT_BODY,
    PH_EVT_SKIP,
    PH_ACL_HDR,
    PH_ACL_BODY
  } phase_t;

  phase_t                 phase, phase_next;
  logic [15:0]            seen, seen_next;
  logic [15:0]            body_len, body_len_next;
  logic                   adv_seen, adv_seen_next;
  logic [3:0][7:0]        hdr;
  logic [EVT_LIMIT_W-1:0] evt_limit;
  logic [ACL_LIMIT_W-1:0] acl_limit;

  logic        fire;
  logic [7:0]  b;
  logic [16:0] seen_inc;
  logic        hdr_we;
  logic [1:0]  hdr_idx;
  logic        push_c;
  logic        adv_now;
  logic        last;
  logic [15:0] acl_len;

  assign link.ready = !q_full;
  assign fire       = link.valid && link.ready;
  assign b          = link.rx_byte;
  assign seen_inc   = {1'b0, seen} + 17'd1;
  assign acl_len    = {b, hdr[2]};
  assign q_push     = fire && push_c;

  always_comb begin
    phase_next    = phase;
    seen_next     = seen;
    body_len_next = body_len;
    adv_seen_next = adv_seen;
    hdr_we        = 1'b0;
    hdr_idx       = seen[1:0];
    push_c        = 1'b0;
    q_cmd         = '0;
    adv_now       = adv_seen;
    last          = 1'b0;
    unique case (phase)
      PH_HUNT: begin
        if (b == TYPE_EVENT) begin
          phase_next = PH_EVT_HDR;
          seen_next  = '0;
        end else if (b == TYPE_ACL) begin
          phase_next = PH_ACL_HDR;
          seen_next  = '0;
        end
      end
      PH_EVT_HDR: begin
        hdr_we  = 1'b1;
        hdr_idx = {1'b0, seen[0]};
        if (seen[0]) begin
          body_len_next = {8'h00, b};
          adv_seen_next = 1'b0;
          seen_next     = '0;
          if (({2'b00, b} + EVT_HDR_BYTES) > {1'b0, evt_limit}) begin
            // oversize: an empty one is reported at once, others skipped first
            if (b == 8'h00) begin
              push_c     = 1'b1;
              q_cmd.op   = OP_EVT_DROP;
              q_cmd.last = 1'b1;
              phase_next = PH_HUNT;
            end else begin
              phase_next = PH_EVT_SKIP;
            end
          end else begin
            push_c        = 1'b1;
            q_cmd.op      = OP_EVT_HDR;
            q_cmd.data[0] = hdr[0];
            q_cmd.data[1] = b;
            q_cmd.last    = (b == 8'h00);
            phase_next    = (b == 8'h00) ? PH_HUNT : PH_EVT_BODY;
          end
        end else begin
          seen_next = seen_inc[15:0];
        end
      end
      PH_EVT_BODY: begin
        adv_now = adv_seen || (seen == 16'd0 && hdr[0] == EVT_LE_META &&
                  (b == SUBEV_ADV_REPORT || b == SUBEV_EXT_ADV_REPORT));
        adv_seen_next = adv_now;
        last          = (seen_inc == {1'b0, body_len});
        seen_next     = seen_inc[15:0];
        push_c        = 1'b1;
        q_cmd.op      = OP_BYTE;
        q_cmd.data[0] = b;
        q_cmd.last    = last;
        q_cmd.disc    = last && adv_now;
        if (last) begin
          phase_next = PH_HUNT;
        end
      end
      PH_EVT_SKIP: begin
        seen_next = seen_inc[15:0];
        if (seen_inc == {1'b0, body_len}) begin
          push_c     = 1'b1;
          q_cmd.op   = OP_EVT_DROP;
          q_cmd.last = 1'b1;
          phase_next = PH_HUNT;
        end
      end
      PH_ACL_HDR: begin
        hdr_we = 1'b1;
        if (seen[1:0] == 2'd3) begin
          body_len_next = acl_len;
          seen_next     = '0;
          push_c        = 1'b1;
          if (acl_len > acl_limit) begin
            q_cmd.op   = OP_ACL_DROP;
            q_cmd.last = 1'b1;
            phase_next = PH_HUNT;
          end else begin
            q_cmd.op      = OP_ACL_HDR;
            q_cmd.data[0] = hdr[0];
            q_cmd.data[1] = hdr[1];
            q_cmd.data[2] = hdr[2];
            q_cmd.data[3] = b;
            q_cmd.acl     = 1'b1;
            q_cmd.last    = (acl_len == 16'd0);
            phase_next    = (acl_len == 16'd0) ? PH_HUNT : PH_ACL_BODY;
          end
        end else begin
          seen_next = seen_inc[15:0];
        end
      end
      PH_ACL_BODY: begin
        last          = (seen_inc == {1'b0, body_len});
        seen_next     = seen_inc[15:0];
        push_c        = 1'b1;
        q_cmd.op      = OP_BYTE;
        q_cmd.data[0] = b;
        q_cmd.acl     = 1'b1;
        q_cmd.last    = last;
        if (last) begin
          phase_next = PH_HUNT;
        end
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HUNT;
      seen      <= '0;
      body_len  <= '0;
      adv_seen  <= 1'b0;
      evt_limit <= EVT_LIMIT_RESET;
      acl_limit <= ACL_LIMIT_RESET;
    end else begin
      if (fire) begin
        phase    <= phase_next;
        seen     <= seen_next;
        body_len <= body_len_next;
        adv_seen <= adv_seen_next;
      end
      if (cfg_we) begin
        if (cfg_index == CFG_EVENT_SIZE_LIMIT) begin
          evt_limit <= cfg_data[EVT_LIMIT_W-1:0];
        end else if (cfg_index == CFG_ACL_PAYLOAD_LIMIT) begin
          acl_limit <= cfg_data[ACL_LIMIT_W-1:0];
        end
      end
    end
  end

  // header bytes need no reset: each is written before it is read
  always_ff @(posedge clk) begin
    if (fire && hdr_we) begin
      hdr[hdr_idx] <= b;
    end
  end

endmodule

// ----- rtl/hci_h4_queue.sv -----
// Short command queue between the front and back parts.
// Depends on hci_h4_pkg for the command type.
module hci_h4_queue import hci_h4_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic head_valid
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full       = (count == CNT_FULL);
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ----- rtl/hci_h4_back.sv -----
// Back part: expands queued commands into packet words, keeps the drop
// counters and holds the output register. Depends on hci_h4_pkg, hci_h4_pkt_if and the assertion header.
`include "hci_uart_h4_deframer_assert.svh"
module hci_h4_back import hci_h4_pkg::*; #(
  parameter int DROP_COUNT_WIDTH = DROP_COUNT_WIDTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  cmd_t         head,
  input  logic         head_valid,
  output logic         pop,
  hci_h4_pkt_if.source packet
);

  logic [1:0]                  beat;
  logic [1:0]                  beat_last;
  logic [DROP_COUNT_WIDTH-1:0] evt_cnt, evt_cnt_next;
  logic [DROP_COUNT_WIDTH-1:0] acl_cnt, acl_cnt_next;
  logic                        out_valid;
  logic                        load;

  logic [7:0] w_byte;
  kind_t      w_kind;
  logic       w_first;
  logic       w_last;
  logic       w_disc;

  assign load         = head_valid && (!out_valid || packet.ready);
  assign pop          = load && (beat == beat_last);
  assign packet.valid = out_valid;

  always_comb begin
    beat_last    = 2'd0;
    w_byte       = 8'h00;
    w_kind       = KIND_EVT_BYTE;
    w_first      = 1'b0;
    w_last       = 1'b0;
    w_disc       = 1'b0;
    evt_cnt_next = evt_cnt;
    acl_cnt_next = acl_cnt;
    unique case (head.op)
      OP_BYTE: begin
        w_byte = head.data[0];
        w_kind = head.acl ? KIND_ACL_BYTE : KIND_EVT_BYTE;
        w_last = head.last;
        w_disc = head.disc;
      end
      OP_EVT_HDR: begin
        beat_last = 2'd1;
        w_byte    = head.data[beat];
        w_first   = (beat == 2'd0);
        w_last    = (beat == 2'd1) && head.last;
      end
      OP_ACL_HDR: begin
        beat_last = 2'd3;
        w_byte    = head.data[beat];
        w_kind    = KIND_ACL_BYTE;
        w_first   = (beat == 2'd0);
        w_last    = (beat == 2'd3) && head.last;
      end
      OP_EVT_DROP: begin
        w_kind       = KIND_EVT_DROP;
        w_last       = 1'b1;
        evt_cnt_next = evt_cnt + 1'b1;
      end
      OP_ACL_DROP: begin
        w_kind       = KIND_ACL_DROP;
        w_last       = 1'b1;
        acl_cnt_next = acl_cnt + 1'b1;
      end
      default: begin
        w_last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat      <= '0;
      evt_cnt   <= '0;
      acl_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        beat      <= (beat == beat_last) ? 2'd0 : beat + 2'd1;
        evt_cnt   <= evt_cnt_next;
        acl_cnt   <= acl_cnt_next;
        out_valid <= 1'b1;
      end else if (packet.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload of the output register; words carry the counters after update
  always_ff @(posedge clk) begin
    if (load) begin
      packet.out_byte            <= w_byte;
      packet.out_kind            <= w_kind;
      packet.first_of_packet     <= w_first;
      packet.last_of_packet      <= w_last;
      packet.discardable         <= w_disc;
      packet.dropped_event_total <= COUNT_OUT_W'(evt_cnt_next);
      packet.dropped_acl_total   <= COUNT_OUT_W'(acl_cnt_next);
    end
  end

  `HCI_H4_ASSERT_NEXT(a_evt_drop_counts, clk, rst, load && head.op == OP_EVT_DROP, evt_cnt == $past(evt_cnt) + 1'b1, "event drop notice without counter step")
  `HCI_H4_ASSERT_NOW(a_beat_in_header, clk, rst, beat != 2'd0, head_valid && (head.op == OP_EVT_HDR || head.op == OP_ACL_HDR), "beat index outside a header")
  `HCI_H4_ASSERT_NEXT(a_pop_rewinds_beat, clk, rst, pop, beat == 2'd0, "beat index not rewound after pop")

endmodule

// ----- rtl/hci_uart_h4_deframer.sv -----
// HCI H4 UART receive deframer. Splits received bytes into event (type 0x04)
// and ACL (type 0x02) packets; other bytes are dropped while hunting for a
// type byte. Rate: one received byte per cycle while the command queue (four
// entries by default) has room; while packet.ready does not hold the output,
// body bytes leave at one word per cycle and a completed header leaves as two
// (event) or four (ACL) words, one per cycle. Oversize packets produce one drop
// notice and step a wrapping counter. Limits are written through cfg_we/cfg_index/
// cfg_data while the block is idle, a rule for the user that the block does not
// enforce, and are sampled when a header completes.
// Depends on hci_h4_pkg, the channel interfaces and the three submodules.
module hci_uart_h4_deframer import hci_h4_pkg::*; #(
  parameter int DROP_COUNT_WIDTH = DROP_COUNT_WIDTH_DEFAULT,
  parameter int QUEUE_DEPTH      = QUEUE_DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  hci_h4_rx_if.sink              link,
  hci_h4_pkt_if.source           packet,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic q_push, q_full, q_pop, q_head_valid;
  cmd_t q_cmd, q_head;

  hci_h4_front u_front (
    .clk       (clk),
    .rst       (rst),
    .link      (link),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  hci_h4_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_head_valid)
  );

  hci_h4_back #(
    .DROP_COUNT_WIDTH (DROP_COUNT_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .head_valid (q_head_valid),
    .pop        (q_pop),
    .packet     (packet)
  );

endmodule
